### rtl/core/keyed_event_count_table_core_defines.svh
// ----------------------------------------------------------------------------
// keyed event count table core - assertion macros
// shared concurrent check forms, clocked on i_clk, quiet while in reset
// ----------------------------------------------------------------------------
`ifndef KEYED_EVENT_COUNT_TABLE_CORE_DEFINES_SVH
`define KEYED_EVENT_COUNT_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define KECT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KECT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/kect_pkg.sv
// ----------------------------------------------------------------------------
// kect_pkg
// types and codes shared by the keyed event count table core
// ----------------------------------------------------------------------------
package kect_pkg;

    localparam int DEFAULT_ENTRIES = 10;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_DUMP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_DUMP     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_key;
        logic [15:0] entry_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic key_we;
        logic cnt_we;
        logic ord_we;
    } t_tbl_we;

endpackage

### rtl/core/kect_table.sv
// ----------------------------------------------------------------------------
// kect_table
// entry key, count and list order storage with one read position per cycle
// ----------------------------------------------------------------------------
module kect_table #(
    parameter int ENTRIES = kect_pkg::DEFAULT_ENTRIES,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic            i_clk,
    input  kect_pkg::t_tbl_we i_we,
    input  logic [IW-1:0]   i_wr_slot,
    input  logic [7:0]      i_wr_key,
    input  logic [15:0]     i_wr_cnt,
    input  logic [IW-1:0]   i_wr_pos,
    input  logic [IW-1:0]   i_wr_ord,
    input  logic [IW-1:0]   i_rd_pos,
    output logic [IW-1:0]   o_rd_slot,
    output logic [7:0]      o_rd_key,
    output logic [15:0]     o_rd_cnt
);

    logic [7:0]    r_keys [ENTRIES];
    logic [15:0]   r_cnts [ENTRIES];
    logic [IW-1:0] r_ord  [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we.key_we) begin
            r_keys[i_wr_slot] <= i_wr_key;
        end
        if (i_we.cnt_we) begin
            r_cnts[i_wr_slot] <= i_wr_cnt;
        end
        if (i_we.ord_we) begin
            r_ord[i_wr_pos] <= i_wr_ord;
        end
    end

    assign o_rd_slot = r_ord[i_rd_pos];
    assign o_rd_key  = r_keys[o_rd_slot];
    assign o_rd_cnt  = r_cnts[o_rd_slot];

endmodule

### rtl/core/keyed_event_count_table_core.sv
// ----------------------------------------------------------------------------
// keyed_event_count_table_core
// counts occurrences of 8-bit keys in a small table kept in recency order
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every result
// word is shown on o_result for exactly one cycle with o_strobe high and
// cannot be held off, so the receiver must take it in that cycle. Results
// appear from the cycle after acceptance on. Clear and a dump of an empty
// table are answered from idle and leave busy low. A record walks the list
// one position a cycle through the single table read port: a miss appends
// the key with count 1, or drops it when the table is full; a hit bumps the
// count, reports it and then moves the entry to the end of the list. A dump
// gives one entry word per cycle. Mode 3 is ignored.
// ----------------------------------------------------------------------------
`include "keyed_event_count_table_core_defines.svh"

module keyed_event_count_table_core #(
    parameter int ENTRIES = kect_pkg::DEFAULT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  kect_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output kect_pkg::t_result o_result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_pos, n_pos;
    logic [IW-1:0]     r_slot, n_slot;
    logic [7:0]        r_key, n_key;
    logic              r_strobe, n_strobe;
    kect_pkg::t_result r_res, n_res;

    kect_pkg::t_tbl_we w_we;
    logic [IW-1:0]     w_wr_slot;
    logic [7:0]        w_wr_key;
    logic [15:0]       w_wr_cnt;
    logic [IW-1:0]     w_wr_pos;
    logic [IW-1:0]     w_wr_ord;
    logic [IW-1:0]     w_rd_pos;
    logic [IW-1:0]     w_rd_slot;
    logic [7:0]        w_rd_key;
    logic [15:0]       w_rd_cnt;
    logic [CW-1:0]     w_pos_inc;
    logic [15:0]       w_cnt_inc;

    kect_table #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_slot (w_wr_slot),
        .i_wr_key  (w_wr_key),
        .i_wr_cnt  (w_wr_cnt),
        .i_wr_pos  (w_wr_pos),
        .i_wr_ord  (w_wr_ord),
        .i_rd_pos  (w_rd_pos),
        .o_rd_slot (w_rd_slot),
        .o_rd_key  (w_rd_key),
        .o_rd_cnt  (w_rd_cnt)
    );

    assign w_pos_inc = r_pos + CW'(1);
    assign w_cnt_inc = (w_rd_cnt == kect_pkg::COUNT_MAX) ? w_rd_cnt : w_rd_cnt + 16'd1;

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_key     = r_key;
        n_strobe  = 1'b0;
        n_res     = r_res;
        w_we      = '0;
        w_wr_slot = w_rd_slot;
        w_wr_key  = r_key;
        w_wr_cnt  = w_cnt_inc;
        w_wr_pos  = r_pos[IW-1:0];
        w_wr_ord  = w_rd_slot;
        w_rd_pos  = r_pos[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = i_cmd.key;
                    n_pos = '0;
                    unique case (i_cmd.mode)
                        kect_pkg::MODE_RECORD: begin
                            n_state = S_SCAN;
                        end
                        kect_pkg::MODE_DUMP: begin
                            if (r_used == '0) begin
                                n_strobe = 1'b1;
                                n_res    = '{kect_pkg::ST_EMPTY, 8'd0, 16'd0, 1'b1};
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        kect_pkg::MODE_CLEAR: begin
                            n_used   = '0;
                            n_strobe = 1'b1;
                            n_res    = '{kect_pkg::ST_CLEARED, 8'd0, 16'd0, 1'b1};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pos == r_used) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_used == CW'(ENTRIES)) begin
                        n_res = '{kect_pkg::ST_DROPPED, 8'd0, 16'd0, 1'b1};
                    end else begin
                        w_we      = '{key_we: 1'b1, cnt_we: 1'b1, ord_we: 1'b1};
                        w_wr_slot = r_used[IW-1:0];
                        w_wr_cnt  = 16'd1;
                        w_wr_pos  = r_used[IW-1:0];
                        w_wr_ord  = r_used[IW-1:0];
                        n_used    = r_used + CW'(1);
                        n_res     = '{kect_pkg::ST_RECORDED, r_key, 16'd1, 1'b1};
                    end
                end else if (w_rd_key == r_key) begin
                    w_we.cnt_we = 1'b1;
                    n_slot      = w_rd_slot;
                    n_strobe    = 1'b1;
                    n_res       = '{kect_pkg::ST_RECORDED, r_key, w_cnt_inc, 1'b1};
                    n_state     = S_SHIFT;
                end else begin
                    n_pos = w_pos_inc;
                end
            end
            S_SHIFT: begin
                w_we.ord_we = 1'b1;
                if (w_pos_inc < r_used) begin
                    // pull the next position down one place
                    w_rd_pos = w_pos_inc[IW-1:0];
                    n_pos    = w_pos_inc;
                end else begin
                    w_wr_ord = r_slot;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                n_strobe = 1'b1;
                n_res    = '{kect_pkg::ST_DUMP, w_rd_key, w_rd_cnt, w_pos_inc == r_used};
                n_pos    = w_pos_inc;
                if (w_pos_inc == r_used) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_strobe <= n_strobe;
        end
        r_pos  <= n_pos;
        r_slot <= n_slot;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `KECT_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CW'(ENTRIES), "entry count beyond table size")
    `KECT_ASSERT_NOW(a_dump_nonzero, o_strobe && o_result.status == kect_pkg::ST_DUMP,
        o_result.entry_count != 16'd0, "dumped entry with zero count")
    `KECT_ASSERT_NOW(a_single_last, o_strobe && o_result.status != kect_pkg::ST_DUMP,
        o_result.last, "single result word without last")
    `KECT_ASSERT_NEXT(a_clear, start && !busy && i_cmd.mode == kect_pkg::MODE_CLEAR,
        o_strobe && o_result.status == kect_pkg::ST_CLEARED && r_used == '0,
        "clear did not empty the table")

endmodule
